FILE: rtl/core/hgg_pkg.sv
// ----------------------------------------------------------------------------
// hgg_pkg
// Types and constants of the height grid gradient block.
// ----------------------------------------------------------------------------
package hgg_pkg;

  // Field widths
  localparam int HEIGHT_W     = 16;
  localparam int DIFF_W       = HEIGHT_W + 1;
  localparam int GRAD_W       = 24;
  localparam int LINE_W       = 16;
  localparam int POS_W        = 10;

  // Configuration port
  localparam int CFG_LINES_W  = 16;
  localparam int CFG_LEN_W    = 11;
  localparam int CFG_INV_W    = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LINES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RES     = 2'd2;

  localparam logic [CFG_LINES_W-1:0] GRID_LINES_RST  = 16'd2;
  localparam logic [CFG_LEN_W-1:0]   LINE_LENGTH_RST = 11'd2;
  localparam logic [CFG_INV_W-1:0]   INV_RES_RST     = 16'd256;

  // Request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // Queue depths
  localparam int WORK_DEPTH   = 4;
  localparam int RESULT_DEPTH = 4;
  localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

  typedef struct packed {
    logic [CFG_LINES_W-1:0] grid_lines;
    logic [CFG_LEN_W-1:0]   line_length;
    logic [CFG_INV_W-1:0]   inverse_resolution;
  } cfg_t;

  typedef struct packed {
    logic                       opcode;
    logic signed [HEIGHT_W-1:0] height;
  } in_item_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [LINE_W-1:0]        line_index;
    logic [POS_W-1:0]         position_index;
    logic                     frame_end;
  } out_item_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic                     central_x;
    logic                     central_y;
    logic [LINE_W-1:0]        line_index;
    logic [POS_W-1:0]         position_index;
    logic                     frame_end;
  } work_t;

endpackage

FILE: rtl/core/height_grid_gradient_top.sv
// ----------------------------------------------------------------------------
// height_grid_gradient_top
// Streaming central-difference gradient of a height map with two line stores.
// ----------------------------------------------------------------------------
//  channel   ports                           request accepted when
//  in        in_push  in_item  in_full       in_push  && !in_full
//  out       out_pop  out_item out_empty     out_pop  && !out_empty
//  cfg       cfg_we   cfg_index cfg_data     cfg_we
//
//  One request per cycle, sustained while in_full stays low. A taken request
//  reaches out_item through the work queue, multiply stage, round and
//  saturate stage and result queue.
//  Reset is synchronous; the line stores are not cleared and hold no valid bits.
//  A stalled consumer fills the four-entry result queue, then the four-entry
//  work queue, and then in_full rises.
// ----------------------------------------------------------------------------
module height_grid_gradient_top #(
  parameter int MAX_LINE_LENGTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  hgg_pkg::in_item_t                in_item,
  output logic                             in_full,
  input  logic                             out_pop,
  output hgg_pkg::out_item_t               out_item,
  output logic                             out_empty,
  input  logic                             cfg_we,
  input  logic [hgg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hgg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  hgg_pkg::cfg_t                         cfg_r;
  logic                                  wq_push, wq_full, wq_pop, wq_empty;
  hgg_pkg::work_t                        wq_in, wq_out;
  logic                                  rq_push;
  hgg_pkg::out_item_t                    rq_in;
  logic [hgg_pkg::RESULT_CNT_W-1:0]      rq_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_lines         <= hgg_pkg::GRID_LINES_RST;
      cfg_r.line_length        <= hgg_pkg::LINE_LENGTH_RST;
      cfg_r.inverse_resolution <= hgg_pkg::INV_RES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hgg_pkg::CFG_GRID_LINES: begin
          cfg_r.grid_lines <= cfg_data[hgg_pkg::CFG_LINES_W-1:0];
        end
        hgg_pkg::CFG_LINE_LENGTH: begin
          cfg_r.line_length <= cfg_data[hgg_pkg::CFG_LEN_W-1:0];
        end
        hgg_pkg::CFG_INV_RES: begin
          cfg_r.inverse_resolution <= cfg_data[hgg_pkg::CFG_INV_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_full = wq_full;

  hgg_front #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_item (in_item),
    .wq_full (wq_full),
    .wq_push (wq_push),
    .wq_data (wq_in)
  );

  hgg_queue #(
    .item_t (hgg_pkg::work_t),
    .DEPTH  (hgg_pkg::WORK_DEPTH)
  ) u_work_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (wq_push),
    .push_data (wq_in),
    .full      (wq_full),
    .pop       (wq_pop),
    .pop_data  (wq_out),
    .empty     (wq_empty),
    .count     ()
  );

  hgg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .inv_res  (cfg_r.inverse_resolution),
    .wq_empty (wq_empty),
    .wq_data  (wq_out),
    .wq_pop   (wq_pop),
    .rq_count (rq_count),
    .rq_push  (rq_push),
    .rq_data  (rq_in)
  );

  hgg_queue #(
    .item_t (hgg_pkg::out_item_t),
    .DEPTH  (hgg_pkg::RESULT_DEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rq_push),
    .push_data (rq_in),
    .full      (),
    .pop       (out_pop),
    .pop_data  (out_item),
    .empty     (out_empty),
    .count     (rq_count)
  );

endmodule

FILE: rtl/core/hgg_queue.sv
// ----------------------------------------------------------------------------
// hgg_queue
// Small first-in first-out register queue with occupancy count.
// ----------------------------------------------------------------------------
module hgg_queue #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  item_t                      push_data,
  output logic                       full,
  input  logic                       pop,
  output item_t                      pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           entry_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/hgg_front.sv
// ----------------------------------------------------------------------------
// hgg_front
// Accepts requests, keeps the raster counters and both line stores, turns
// samples past line zero and drains of a full grid into difference requests.
// ----------------------------------------------------------------------------
module hgg_front #(
  parameter int MAX_LINE_LENGTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hgg_pkg::cfg_t     cfg,
  input  logic              in_push,
  input  hgg_pkg::in_item_t in_item,
  input  logic              wq_full,
  output logic              wq_push,
  output hgg_pkg::work_t    wq_data
);

  localparam int HW = hgg_pkg::HEIGHT_W;
  localparam int DW = hgg_pkg::DIFF_W;
  localparam int LN = hgg_pkg::LINE_W;
  localparam int PW = (MAX_LINE_LENGTH > 1) ? $clog2(MAX_LINE_LENGTH) : 1;
  localparam int LW = $clog2(MAX_LINE_LENGTH + 1);

  logic signed [HW-1:0] older_mem [MAX_LINE_LENGTH];
  logic signed [HW-1:0] newer_mem [MAX_LINE_LENGTH];

  logic [LN-1:0]        line_r, line_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [PW-1:0]        drain_r, drain_nxt;
  logic                 full_r, full_nxt;
  logic signed [HW-1:0] prev_mid_r, prev_mid_nxt;
  logic signed [HW-1:0] rd_mid_r, rd_up_r, rd_right_r;

  logic [LN-1:0]        eff_lines;
  logic [LW-1:0]        eff_len;
  logic                 accept, is_drain, do_sample, do_drain;
  logic [PW-1:0]        p;
  logic [PW:0]          p_inc;
  logic                 p_end;
  logic [LN:0]          x_inc;
  logic                 x_last;
  logic [31:0]          p32;
  logic signed [HW-1:0] h;
  logic [PW-1:0]        rd_addr, rd_addr_right;

  function automatic logic signed [DW-1:0] hdiff(input logic signed [HW-1:0] a,
                                                 input logic signed [HW-1:0] b);
    hdiff = $signed({a[HW-1], a}) - $signed({b[HW-1], b});
  endfunction

  // Effective bounds: both counts are at least two, length at most the store
  always_comb begin
    eff_lines = (cfg.grid_lines < 16'd2) ? 16'd2 : cfg.grid_lines;
    if (cfg.line_length < 11'd2) begin
      eff_len = LW'(2);
    end else if (32'(cfg.line_length) > MAX_LINE_LENGTH) begin
      eff_len = LW'(MAX_LINE_LENGTH);
    end else begin
      eff_len = LW'(cfg.line_length);
    end
  end

  assign h         = in_item.height;
  assign accept    = in_push && !wq_full;
  assign is_drain  = (in_item.opcode == hgg_pkg::OP_DRAIN);
  assign do_sample = accept && !is_drain && !full_r;
  assign do_drain  = accept && is_drain && full_r;

  assign p      = is_drain ? drain_r : pos_r;
  assign p_inc  = {1'b0, p} + 1'b1;
  assign p_end  = (32'(p_inc) >= 32'(eff_len));
  assign x_inc  = {1'b0, line_r} + 1'b1;
  assign x_last = (x_inc >= {1'b0, eff_lines});
  assign p32    = 32'(p);

  // Classify the request and form the differences
  always_comb begin
    wq_push = do_drain || (do_sample && (line_r != '0));

    if (is_drain) begin
      wq_data.diff_x    = hdiff(rd_up_r, rd_mid_r);
      wq_data.central_x = 1'b0;
    end else if (line_r == 16'd1) begin
      wq_data.diff_x    = hdiff(rd_mid_r, h);
      wq_data.central_x = 1'b0;
    end else if (line_r >= eff_lines) begin
      wq_data.diff_x    = hdiff(rd_up_r, rd_mid_r);
      wq_data.central_x = 1'b0;
    end else begin
      wq_data.diff_x    = hdiff(rd_up_r, h);
      wq_data.central_x = 1'b1;
    end

    if (p == '0) begin
      wq_data.diff_y    = hdiff(rd_right_r, rd_mid_r);
      wq_data.central_y = 1'b0;
    end else if (p_end) begin
      wq_data.diff_y    = hdiff(rd_mid_r, prev_mid_r);
      wq_data.central_y = 1'b0;
    end else begin
      wq_data.diff_y    = hdiff(rd_right_r, prev_mid_r);
      wq_data.central_y = 1'b1;
    end

    wq_data.line_index     = is_drain ? line_r : line_r - 16'd1;
    wq_data.position_index = p32[hgg_pkg::POS_W-1:0];
    wq_data.frame_end      = is_drain && p_end;
  end

  // Raster counters
  always_comb begin
    line_nxt     = line_r;
    pos_nxt      = pos_r;
    drain_nxt    = drain_r;
    full_nxt     = full_r;
    prev_mid_nxt = prev_mid_r;
    if (do_sample) begin
      prev_mid_nxt = rd_mid_r;
      if (p_end) begin
        pos_nxt = '0;
        if (x_last) begin
          full_nxt  = 1'b1;
          drain_nxt = '0;
        end else begin
          line_nxt = x_inc[LN-1:0];
        end
      end else begin
        pos_nxt = p_inc[PW-1:0];
      end
    end else if (do_drain) begin
      prev_mid_nxt = rd_mid_r;
      if (p_end) begin
        full_nxt  = 1'b0;
        line_nxt  = '0;
        pos_nxt   = '0;
        drain_nxt = '0;
      end else begin
        drain_nxt = p_inc[PW-1:0];
      end
    end
  end

  // Prefetch the entries the next request will need
  assign rd_addr       = full_nxt ? drain_nxt : pos_nxt;
  assign rd_addr_right = (32'(rd_addr) >= 32'(MAX_LINE_LENGTH - 1)) ? rd_addr
                                                                     : rd_addr + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= '0;
      pos_r   <= '0;
      drain_r <= '0;
      full_r  <= 1'b0;
    end else begin
      line_r  <= line_nxt;
      pos_r   <= pos_nxt;
      drain_r <= drain_nxt;
      full_r  <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_mid_r <= prev_mid_nxt;
  end

  // Line stores: shift the newer line down and forward a same-cycle write
  always_ff @(posedge clk) begin
    if (do_sample) begin
      older_mem[p] <= rd_mid_r;
      newer_mem[p] <= h;
    end
    rd_mid_r   <= (do_sample && (p == rd_addr)) ? h : newer_mem[rd_addr];
    rd_up_r    <= (do_sample && (p == rd_addr)) ? rd_mid_r : older_mem[rd_addr];
    rd_right_r <= (do_sample && (p == rd_addr_right)) ? h : newer_mem[rd_addr_right];
  end

endmodule

FILE: rtl/core/hgg_back.sv
// ----------------------------------------------------------------------------
// hgg_back
// Scales the differences by the inverse resolution, rounds, saturates and
// hands finished results to the result queue.
// ----------------------------------------------------------------------------
module hgg_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [hgg_pkg::CFG_INV_W-1:0]       inv_res,
  input  logic                                wq_empty,
  input  hgg_pkg::work_t                      wq_data,
  output logic                                wq_pop,
  input  logic [hgg_pkg::RESULT_CNT_W-1:0]    rq_count,
  output logic                                rq_push,
  output hgg_pkg::out_item_t                  rq_data
);

  localparam int DW     = hgg_pkg::DIFF_W;
  localparam int GW     = hgg_pkg::GRAD_W;
  localparam int PRODW  = DW + hgg_pkg::CFG_INV_W + 1;
  localparam int QW     = PRODW + 1;
  localparam int IW     = hgg_pkg::RESULT_CNT_W + 1;
  localparam int SH_ONE = 8;
  localparam int SH_CEN = 9;

  localparam logic [QW-1:0] HALF_ONE    = QW'(1) << (SH_ONE - 1);
  localparam logic [QW-1:0] HALF_CEN    = QW'(1) << (SH_CEN - 1);
  localparam logic [QW-1:0] SAT_POS_MAG = (QW'(1) << (GW - 1)) - QW'(1);
  localparam logic [QW-1:0] SAT_NEG_MAG = QW'(1) << (GW - 1);

  logic                    s1_v_r;
  logic signed [PRODW-1:0] s1_px_r, s1_py_r;
  hgg_pkg::work_t          s1_work_r;
  logic                    s2_v_r;
  hgg_pkg::out_item_t      s2_item_r;
  logic [IW-1:0]           occupancy;
  logic signed [PRODW-1:0] inv_s;

  // Round half away from zero, then clamp to the output range
  function automatic logic signed [GW-1:0] round_sat(input logic signed [PRODW-1:0] prod,
                                                     input logic central);
    logic [PRODW-1:0] mag;
    logic [QW-1:0]    rnd;
    logic [QW-1:0]    q;
    logic [QW-1:0]    neg;
    mag = prod[PRODW-1] ? PRODW'(-prod) : PRODW'(prod);
    rnd = {1'b0, mag} + (central ? HALF_CEN : HALF_ONE);
    q   = central ? (rnd >> SH_CEN) : (rnd >> SH_ONE);
    neg = ~q + 1'b1;
    if (prod[PRODW-1]) begin
      round_sat = (q > SAT_NEG_MAG) ? {1'b1, {(GW-1){1'b0}}} : neg[GW-1:0];
    end else begin
      round_sat = (q > SAT_POS_MAG) ? SAT_POS_MAG[GW-1:0] : q[GW-1:0];
    end
  endfunction

  // Issue only with a free result slot for everything in flight
  assign occupancy = IW'(rq_count) + IW'(s1_v_r) + IW'(s2_v_r);
  assign wq_pop    = !wq_empty && (32'(occupancy) < hgg_pkg::RESULT_DEPTH);
  assign inv_s     = PRODW'($signed({1'b0, inv_res}));
  assign rq_push   = s2_v_r;
  assign rq_data   = s2_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= wq_pop;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wq_pop) begin
      s1_px_r   <= PRODW'(wq_data.diff_x) * inv_s;
      s1_py_r   <= PRODW'(wq_data.diff_y) * inv_s;
      s1_work_r <= wq_data;
    end
    s2_item_r.grad_x         <= round_sat(s1_px_r, s1_work_r.central_x);
    s2_item_r.grad_y         <= round_sat(s1_py_r, s1_work_r.central_y);
    s2_item_r.line_index     <= s1_work_r.line_index;
    s2_item_r.position_index <= s1_work_r.position_index;
    s2_item_r.frame_end      <= s1_work_r.frame_end;
  end

endmodule

FILE: rtl/core/hgg_checker.sv
// ----------------------------------------------------------------------------
// hgg_checker
// Port-level checks of the height grid gradient block, bound to the top.
// ----------------------------------------------------------------------------
module hgg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_push,
  input hgg_pkg::in_item_t                in_item,
  input logic                             in_full,
  input logic                             out_pop,
  input hgg_pkg::out_item_t               out_item,
  input logic                             out_empty,
  input logic                             cfg_we,
  input logic [hgg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [hgg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // Back-pressure only builds up behind a request
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("in_full rose without a request");

  // The drain line is never the first line of a frame
  a_frame_end_line: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.frame_end |-> out_item.line_index != 16'd0)
    else $error("frame end reported on line zero");

  // Hold a waiting result
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed");

endmodule

bind height_grid_gradient_top hgg_checker u_checker (.*);

FILE: test/height_grid_gradient_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_grid_gradient_top_tb
// Streams height frames through the gradient block under a range of grid
// sizes and scale factors. A local model of the line stores and counters
// predicts every gradient, which is compared field by field with each popped
// result. Both sides stall in random bursts, except in the final stage.
// ----------------------------------------------------------------------------
module height_grid_gradient_top_tb;
  import hgg_pkg::*;

  localparam int     LINE_STORE_DEPTH = 1024;
  localparam int     CYCLE_LIMIT      = 1000000;
  localparam int     RANDOM_REQUESTS  = 2000;
  localparam int     SETTLE_CYCLES    = 8;
  localparam longint GRAD_MAX         = 8388607;
  localparam longint GRAD_MIN         = -8388608;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_push   = 1'b0;
  in_item_t               in_item   = '0;
  logic                   in_full;
  logic                   out_pop   = 1'b0;
  out_item_t              out_item;
  logic                   out_empty;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_GRID_LINES;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Model copy of the registers and the stream state
  logic [CFG_LINES_W-1:0] grid_lines_q  = GRID_LINES_RST;
  logic [CFG_LEN_W-1:0]   line_length_q = LINE_LENGTH_RST;
  logic [CFG_INV_W-1:0]   inv_res_q     = INV_RES_RST;
  longint                 prev_line [LINE_STORE_DEPTH];
  longint                 last_line [LINE_STORE_DEPTH];
  int unsigned            row_q       = 0;
  int unsigned            col_q       = 0;
  int unsigned            drain_pos_q = 0;
  bit                     grid_full   = 1'b0;

  out_item_t              pending_gradients [$];
  bit                     stalls_on        = 1'b1;
  int                     pop_hold         = 0;
  int                     errors           = 0;
  int                     results_checked  = 0;
  int                     effective_items  = 0;
  int                     frames_done      = 0;
  int                     cycle_count      = 0;

  height_grid_gradient_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("height_grid_gradient_top_tb NOT OK");
      $finish;
    end
  end

  // Consumer: hold pop low in short random bursts
  always @(negedge clk) begin
    if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      out_pop  <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      pop_hold <= $urandom_range(0, 4);
      out_pop  <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  function automatic int unsigned pos_clamp(int unsigned i);
    return (i < LINE_STORE_DEPTH) ? i : LINE_STORE_DEPTH - 1;
  endfunction

  // Multiply by the Q8.8 scale, round half away from zero, saturate
  function automatic logic [GRAD_W-1:0] scale_diff(longint diff, bit central);
    longint prod;
    longint mag;
    longint q;
    int     shift;
    shift = central ? 9 : 8;
    prod  = diff * longint'(inv_res_q);
    mag   = (prod < 0) ? -prod : prod;
    q     = (mag + (longint'(1) << (shift - 1))) >> shift;
    if (prod < 0)
      q = (q > -GRAD_MIN) ? GRAD_MIN : -q;
    else if (q > GRAD_MAX)
      q = GRAD_MAX;
    return GRAD_W'(q);
  endfunction

  function automatic logic [GRAD_W-1:0] grad_along_line(longint lft, longint mid, longint rgt,
                                                        int unsigned pos, int unsigned len);
    if (pos == 0)
      return scale_diff(rgt - mid, 1'b0);
    if (pos + 1 >= len)
      return scale_diff(mid - lft, 1'b0);
    return scale_diff(rgt - lft, 1'b1);
  endfunction

  // Advance the model by one request; returns 1 if the request was not ignored
  function automatic bit predict_gradient(in_item_t req);
    int unsigned lines;
    int unsigned len;
    int unsigned x;
    int unsigned y;
    int unsigned px;
    longint      h;
    longint      up;
    longint      mid;
    longint      lft;
    longint      rgt;
    out_item_t   r;
    lines = (grid_lines_q < 2) ? 2 : grid_lines_q;
    len   = (line_length_q < 2) ? 2 :
            (line_length_q > LINE_STORE_DEPTH) ? LINE_STORE_DEPTH : line_length_q;
    r     = '0;
    if (req.opcode == OP_DRAIN) begin
      if (!grid_full)
        return 1'b0;
      y   = pos_clamp(drain_pos_q);
      mid = last_line[y];
      lft = (y >= 1) ? last_line[pos_clamp(y - 1)] : 0;
      rgt = last_line[pos_clamp(y + 1)];
      r.grad_x         = scale_diff(prev_line[y] - mid, 1'b0);
      r.grad_y         = grad_along_line(lft, mid, rgt, y, len);
      r.line_index     = LINE_W'(row_q);
      r.position_index = POS_W'(y);
      r.frame_end      = (y + 1 >= len);
      pending_gradients.push_back(r);
      if (r.frame_end) begin
        grid_full   = 1'b0;
        row_q       = 0;
        col_q       = 0;
        drain_pos_q = 0;
        frames_done++;
      end else begin
        drain_pos_q = y + 1;
      end
      return 1'b1;
    end
    if (grid_full)
      return 1'b0;
    x = row_q;
    y = pos_clamp(col_q);
    h = req.height;
    if (x >= 1) begin
      px  = x - 1;
      up  = prev_line[y];
      mid = last_line[y];
      lft = (y >= 1) ? prev_line[pos_clamp(y - 1)] : 0;
      rgt = last_line[pos_clamp(y + 1)];
      if (px == 0)
        r.grad_x = scale_diff(mid - h, 1'b0);
      else if (px + 1 >= lines)
        r.grad_x = scale_diff(up - mid, 1'b0);
      else
        r.grad_x = scale_diff(up - h, 1'b1);
      r.grad_y         = grad_along_line(lft, mid, rgt, y, len);
      r.line_index     = LINE_W'(px);
      r.position_index = POS_W'(y);
      r.frame_end      = 1'b0;
      pending_gradients.push_back(r);
    end
    prev_line[y] = last_line[y];
    last_line[y] = h;
    if (y + 1 >= len) begin
      col_q = 0;
      if (x + 1 >= lines) begin
        grid_full   = 1'b1;
        drain_pos_q = 0;
      end else begin
        row_q = (x + 1) & 32'hFFFF;
      end
    end else begin
      col_q = y + 1;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_gradients.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got %p", $time, out_item);
      end else begin
        want = pending_gradients.pop_front();
        check_field("grad_x", $signed(want.grad_x), $signed(out_item.grad_x));
        check_field("grad_y", $signed(want.grad_y), $signed(out_item.grad_y));
        check_field("line_index", want.line_index, out_item.line_index);
        check_field("position_index", want.position_index, out_item.position_index);
        check_field("frame_end", want.frame_end, out_item.frame_end);
        results_checked++;
      end
    end
  end

  // Called and returns at a falling edge; push stays high between requests
  task automatic send_request(logic op, logic signed [HEIGHT_W-1:0] h);
    in_item_t    req;
    int unsigned gap;
    req.opcode = op;
    req.height = h;
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_full);
    if (predict_gradient(req))
      effective_items++;
    @(negedge clk);
  endtask

  // Drop push, wait for every expected result, then let the pipeline drain
  task automatic settle();
    in_push <= 1'b0;
    while (pending_gradients.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_LINES:  grid_lines_q  = data[CFG_LINES_W-1:0];
      CFG_LINE_LENGTH: line_length_q = data[CFG_LEN_W-1:0];
      CFG_INV_RES:     inv_res_q     = data[CFG_INV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(logic [15:0] lines, logic [15:0] len_data, logic [15:0] inv);
    settle();
    set_register(CFG_GRID_LINES, lines);
    set_register(CFG_LINE_LENGTH, len_data);
    set_register(CFG_INV_RES, inv);
  endtask

  function automatic logic signed [HEIGHT_W-1:0] random_height();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return HEIGHT_W'($urandom_range(0, 31)) - 16'd16;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  // Complete the current frame; noisy adds early drains and late samples
  task automatic run_frame(bit noisy);
    int unsigned extra;
    while (!grid_full) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_request(OP_DRAIN, HEIGHT_W'($urandom));
      send_request(OP_SAMPLE, random_height());
    end
    if (noisy && $urandom_range(0, 2) == 0) begin
      extra = $urandom_range(1, 3);
      repeat (extra) send_request(OP_SAMPLE, random_height());
    end
    while (grid_full)
      send_request(OP_DRAIN, HEIGHT_W'($urandom));
  endtask

  // Reset settings: early drain ignored, first line silent, late sample dropped
  task automatic test_reset_frame();
    send_request(OP_DRAIN, 16'sh1234);
    send_request(OP_SAMPLE, 16'sh7FFF);
    send_request(OP_SAMPLE, 16'sh8000);
    send_request(OP_SAMPLE, 16'sh8000);
    send_request(OP_SAMPLE, 16'sh7FFF);
    send_request(OP_SAMPLE, 16'sh0001);
    send_request(OP_DRAIN, 16'sh0000);
    send_request(OP_DRAIN, 16'shFFFF);
  endtask

  // Full scale on a 3x3 grid: saturation, central and one-sided differences
  task automatic test_extreme_heights();
    logic signed [HEIGHT_W-1:0] heights [9];
    heights = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                16'sh8000, 16'sh7FFF, 16'shFFFF,
                16'sh7FFF, 16'sh8000, 16'sh0001};
    configure(16'd3, 16'd3, 16'hFFFF);
    foreach (heights[i])
      send_request(OP_SAMPLE, heights[i]);
    repeat (3) send_request(OP_DRAIN, 16'sh0000);
  endtask

  // Sizes below the floor act as two; upper data bits of the length are ignored
  task automatic test_register_floors();
    configure(16'd1, 16'hF800, 16'd1);
    run_frame(1'b1);
  endtask

  task automatic test_random_frames();
    int unsigned target;
    int unsigned lines_v;
    int unsigned len_v;
    int unsigned inv_v;
    target = effective_items + RANDOM_REQUESTS;
    while (effective_items < target) begin
      case ($urandom_range(0, 19))
        0:       len_v = $urandom_range(0, 1);
        1:       len_v = $urandom_range(1000, 2047);
        default: len_v = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       lines_v = $urandom_range(0, 1);
        8, 9:    lines_v = $urandom_range(7, 40);
        default: lines_v = $urandom_range(2, 6);
      endcase
      if (len_v > 64)
        lines_v = $urandom_range(2, 3);
      case ($urandom_range(0, 9))
        0:       inv_v = 0;
        1:       inv_v = 1;
        2:       inv_v = 65535;
        3:       inv_v = 256;
        default: inv_v = $urandom_range(0, 65535);
      endcase
      configure(16'(lines_v), {5'($urandom), 11'(len_v)}, 16'(inv_v));
      run_frame(1'b1);
    end
  endtask

  // Shrink lines and length part way through a frame; counters past the bound wrap
  task automatic test_mid_frame_change();
    configure(16'd6, 16'd5, 16'd256);
    repeat (13) send_request(OP_SAMPLE, random_height());
    configure(16'd3, 16'd2, 16'd1000);
    run_frame(1'b0);
  endtask

  task automatic test_largest_frames();
    stalls_on = 1'b0;
    configure(16'hFFFF, 16'd2, 16'($urandom));
    run_frame(1'b0);
    configure(16'd2, 16'hFFFF, 16'($urandom));
    run_frame(1'b0);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_frame();
    test_extreme_heights();
    test_register_floors();
    test_random_frames();
    test_mid_frame_change();
    test_largest_frames();
    settle();
    $display("Ran %0d frames from %0d effective requests, %0d gradients checked.",
             frames_done, effective_items, results_checked);
    $display("Grids ranged from 2x2 up to 65535 lines and 1024-sample lines.");
    if (errors == 0) begin
      $display("height_grid_gradient_top_tb OK");
    end else begin
      $display("height_grid_gradient_top_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/hgg_pkg.sv
rtl/core/hgg_queue.sv
rtl/core/hgg_front.sv
rtl/core/hgg_back.sv
rtl/core/height_grid_gradient_top.sv
rtl/core/hgg_checker.sv
test/height_grid_gradient_top_tb.sv
